// File: sv/spv_pkg.sv
// shared types, widths and codes for the sample playback voice
package spv_pkg;

  // default configuration of the sample store and the playhead
  localparam int unsigned SAMPLE_DEPTH_DEF = 65536;
  localparam int unsigned SAMPLE_BITS_DEF  = 16;
  localparam int unsigned FRAC_BITS_DEF    = 16;

  // fixed field widths
  localparam int FRAME_W    = 17;
  localparam int START_W    = 16;
  localparam int STEP_W     = 20;
  localparam int ADDR_W     = 16;
  localparam int WORD_W     = 16;
  localparam int OUT_W      = 16;
  localparam int CMD_W      = 2;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;

  // request kinds
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_TRIGGER = 2'd1,
    CMD_STOP    = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  // register indexes, byte address is four times the index
  typedef enum logic [2:0] {
    REG_RANGE_START  = 3'd0,
    REG_RANGE_END    = 3'd1,
    REG_STEP_RATE    = 3'd2,
    REG_SAMPLE_COUNT = 3'd3,
    REG_REVERSE_ON   = 3'd4,
    REG_SPEED_NEG    = 3'd5,
    REG_LOOP_ON      = 3'd6,
    REG_PINGPONG_ON  = 3'd7
  } reg_idx_t;

  // control handed from the voice logic to the sample path with each request
  typedef struct packed {
    logic               wr;
    logic               rd;
    logic               single;
    logic               voice_active;
    logic               released;
    logic [FRAME_W-1:0] playhead;
  } spv_item_t;

endpackage

// File: sv/spv_sample_path.sv
// sample memory, interpolation pipeline and output register
module spv_sample_path #(
  parameter int unsigned SAMPLE_DEPTH = spv_pkg::SAMPLE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS  = spv_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS    = spv_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  spv_pkg::spv_item_t                 item,
  input  logic [$clog2(SAMPLE_DEPTH)-1:0]    waddr,
  input  logic [SAMPLE_BITS-1:0]             wdata,
  input  logic [$clog2(SAMPLE_DEPTH)-1:0]    rd_addr_a,
  input  logic [$clog2(SAMPLE_DEPTH)-1:0]    rd_addr_b,
  input  logic [FRAC_BITS-1:0]               frac,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // sample_out[15:0], voice_active[16], released[17], playhead_frame[34:18]
  output logic [spv_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import spv_pkg::*;

  localparam int PRW = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int MW  = (SAMPLE_BITS > OUT_W) ? SAMPLE_BITS : OUT_W;
  localparam int OW  = MW + 1;
  localparam logic signed [PRW-1:0] HALF = PRW'(1) <<< (FRAC_BITS - 1);

  logic accept;
  logic en2;
  logic en_out;

  logic signed [SAMPLE_BITS-1:0] mem [SAMPLE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_a;
  logic signed [SAMPLE_BITS-1:0] rd_b;

  logic                 v1;
  spv_item_t            s1_item;
  logic [FRAC_BITS-1:0] s1_frac;

  logic                          v2;
  spv_item_t                     s2_item;
  logic signed [PRW-1:0]         s2_prod;
  logic signed [SAMPLE_BITS-1:0] s2_a;

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [PRW-1:0]         prod_next;
  logic signed [PRW-1:0]         quot;
  logic signed [OW-1:0]          interp;
  logic [OUT_W-1:0]              sample_out;

  // pipeline flow: each stage moves when the next one is empty or moving
  assign en_out   = !m_tvalid || m_tready;
  assign en2      = !v2 || en_out;
  assign in_ready = !v1 || en2;
  assign accept   = in_valid && in_ready;

  // sample store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (accept && item.wr) begin
      mem[waddr] <= wdata;
    end
    if (accept && item.rd) begin
      rd_a <= mem[rd_addr_a];
      rd_b <= mem[rd_addr_b];
    end
  end

  // stage 1: difference times fraction, rounded
  assign frac_s    = {1'b0, s1_frac};
  assign diff      = s1_item.single ? $signed({(SAMPLE_BITS+1){1'b0}}) : (rd_b - rd_a);
  assign prod_next = diff * frac_s + HALF;

  // stage 2: add the floored correction to the left frame
  assign quot       = s2_prod >>> FRAC_BITS;
  assign interp     = OW'(s2_a) + OW'(quot);
  assign sample_out = s2_item.rd ? interp[OUT_W-1:0] : '0;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en_out) begin
        m_tvalid <= v2;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_item <= item;
      s1_frac <= frac;
    end
    if (en2) begin
      s2_item <= s1_item;
      s2_prod <= prod_next;
      s2_a    <= s1_item.single && !s1_item.rd ? '0 : rd_a;
    end
    if (en_out) begin
      m_tdata <= {{(OUT_DATA_W - OUT_W - 2 - FRAME_W){1'b0}}, s2_item.playhead,
                  s2_item.released, s2_item.voice_active, sample_out};
    end
  end

  // a stalled input means every stage holds a result
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> v1 && v2 && m_tvalid && !m_tready)
    else $error("input stalled with a free pipeline stage");

  // output drains when nothing follows
  a_drain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !v2 |=> !m_tvalid)
    else $error("result repeated after being taken");

endmodule

// File: sv/sample_playback_voice.sv
// sampler voice top level: registers, playhead control and stream ports
// a result passes through stage 1, stage 2 and the output register on its way to m_tdata
// throughput: one request per cycle while the output is taken; a tick reads frames i and i+1 through
//   the two read ports of the sample store in the same cycle
// a full output register with m_tready low backs up three stages, then s_tready drops
// reset clears the voice and the playhead and sets the registers to their defaults; the sample store is not cleared
module sample_playback_voice #(
  parameter int unsigned SAMPLE_DEPTH = spv_pkg::SAMPLE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS  = spv_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS    = spv_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // addr[15:0], sample_word[31:16], start_frame[48:32], use_given_pos[49]
  input  logic [spv_pkg::IN_DATA_W-1:0]   s_tdata,
  // cmd[1:0]
  input  logic [spv_pkg::CMD_W-1:0]       s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // sample_out[15:0], voice_active[16], released[17], playhead_frame[34:18]
  output logic [spv_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spv_pkg::PADDR_W-1:0]     paddr,
  input  logic [spv_pkg::PDATA_W-1:0]     pwdata,
  output logic [spv_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import spv_pkg::*;

  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int PW = FRAME_W + FRAC_BITS;
  localparam int IW = (AW + 1 > FRAME_W + 1) ? AW + 1 : FRAME_W + 1;
  localparam int MW = (SAMPLE_BITS > WORD_W) ? SAMPLE_BITS : WORD_W;

  // configuration registers
  logic [START_W-1:0] range_start;
  logic [FRAME_W-1:0] range_end;
  logic [STEP_W-1:0]  step_rate;
  logic [FRAME_W-1:0] sample_count;
  logic               reverse_on;
  logic               speed_negative;
  logic               loop_on;
  logic               pingpong_on;

  // voice state
  logic [PW-1:0] play_position;
  logic          play_backward;
  logic          voice_on;
  logic [PW-1:0] play_position_next;
  logic          play_backward_next;
  logic          voice_on_next;

  // request fields
  cmd_t                    cmd;
  logic [ADDR_W-1:0]       addr;
  logic signed [WORD_W-1:0] sample_word;
  logic [FRAME_W-1:0]      start_frame;
  logic                    use_given_pos;
  logic                    accept;
  logic                    cfg_wr;
  reg_idx_t                cfg_idx;

  // range edges
  logic [FRAME_W-1:0] start_plus1;
  logic [FRAME_W-1:0] end_frame;
  logic [PW-1:0]      s_pos;
  logic [PW-1:0]      e_pos;

  // tick move
  logic          pb;
  logic          back;
  logic [PW:0]   sum;
  logic [PW:0]   dif;
  logic [PW:0]   moved;
  logic          hit_end;
  logic          hit_start;
  logic          at_edge;
  logic          rel;
  logic [PW-1:0] move_clamped;
  logic [PW-1:0] tick_pos;
  logic          tick_on;

  // trigger position
  logic [PW-1:0] trig_req;
  logic [PW-1:0] trig_clamped;
  logic [PW-1:0] trig_pos;

  // sample path requests
  logic [IW-1:0]            cnt;
  logic [IW-1:0]            idx;
  logic [IW-1:0]            idx1;
  logic [IW-1:0]            addr_ext;
  logic signed [MW-1:0]     word_ext;
  spv_item_t                item;
  logic                     path_ready;

  assign cmd           = cmd_t'(s_tuser);
  assign addr          = s_tdata[15:0];
  assign sample_word   = s_tdata[31:16];
  assign start_frame   = s_tdata[48:32];
  assign use_given_pos = s_tdata[49];
  assign s_tready      = path_ready;
  assign accept        = s_tvalid && s_tready;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      range_start    <= '0;
      range_end      <= FRAME_W'(65536);
      step_rate      <= STEP_W'(65536);
      sample_count   <= FRAME_W'(65536);
      reverse_on     <= 1'b0;
      speed_negative <= 1'b0;
      loop_on        <= 1'b0;
      pingpong_on    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RANGE_START:  range_start    <= pwdata[START_W-1:0];
        REG_RANGE_END:    range_end      <= pwdata[FRAME_W-1:0];
        REG_STEP_RATE:    step_rate      <= pwdata[STEP_W-1:0];
        REG_SAMPLE_COUNT: sample_count   <= pwdata[FRAME_W-1:0];
        REG_REVERSE_ON:   reverse_on     <= pwdata[0];
        REG_SPEED_NEG:    speed_negative <= pwdata[0];
        REG_LOOP_ON:      loop_on        <= pwdata[0];
        REG_PINGPONG_ON:  pingpong_on    <= pwdata[0];
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_RANGE_START:  prdata = PDATA_W'(range_start);
      REG_RANGE_END:    prdata = PDATA_W'(range_end);
      REG_STEP_RATE:    prdata = PDATA_W'(step_rate);
      REG_SAMPLE_COUNT: prdata = PDATA_W'(sample_count);
      REG_REVERSE_ON:   prdata = PDATA_W'(reverse_on);
      REG_SPEED_NEG:    prdata = PDATA_W'(speed_negative);
      REG_LOOP_ON:      prdata = PDATA_W'(loop_on);
      REG_PINGPONG_ON:  prdata = PDATA_W'(pingpong_on);
    endcase
  end

  // range edges, end kept at least one frame past start
  assign start_plus1 = FRAME_W'(range_start) + FRAME_W'(1);
  assign end_frame   = (range_end < start_plus1) ? start_plus1 : range_end;
  assign s_pos       = {FRAME_W'(range_start), {FRAC_BITS{1'b0}}};
  assign e_pos       = {end_frame, {FRAC_BITS{1'b0}}};

  // direction and step, borrow in the top bit of dif marks a step past zero
  assign pb        = pingpong_on ? play_backward : reverse_on;
  assign back      = pb ^ speed_negative;
  assign sum       = {1'b0, play_position} + (PW+1)'(step_rate);
  assign dif       = {1'b0, play_position} - (PW+1)'(step_rate);
  assign moved     = back ? dif : sum;
  assign hit_end   = !back && (sum >= {1'b0, e_pos});
  assign hit_start = back && (dif[PW] || (dif[PW-1:0] <= s_pos));
  assign at_edge   = hit_end || hit_start;
  assign rel       = at_edge && !loop_on;

  // plain move kept inside the range
  always_comb begin
    if ((back && dif[PW]) || (moved < {1'b0, s_pos})) begin
      move_clamped = s_pos;
    end else if (moved > {1'b0, e_pos}) begin
      move_clamped = e_pos;
    end else begin
      move_clamped = moved[PW-1:0];
    end
  end

  // edge handling: bounce, wrap or one-shot stop
  always_comb begin
    if (at_edge && loop_on && pingpong_on) begin
      tick_pos = hit_end ? e_pos : s_pos;
    end else if (at_edge && loop_on) begin
      tick_pos = hit_end ? s_pos : e_pos;
    end else begin
      tick_pos = move_clamped;
    end
  end

  // trigger start with the reverse-start rule
  assign trig_req = {start_frame, {FRAC_BITS{1'b0}}};
  always_comb begin
    if (trig_req < s_pos) begin
      trig_clamped = s_pos;
    end else if (trig_req > e_pos) begin
      trig_clamped = e_pos;
    end else begin
      trig_clamped = trig_req;
    end
    if (!use_given_pos && (reverse_on ^ speed_negative) && (trig_clamped <= s_pos)) begin
      trig_pos = e_pos;
    end else begin
      trig_pos = trig_clamped;
    end
  end

  // next voice state for the request at the port
  assign tick_on = (cmd == CMD_TICK) && voice_on;
  always_comb begin
    play_position_next = play_position;
    play_backward_next = play_backward;
    voice_on_next      = voice_on;
    unique case (cmd)
      CMD_WRITE: begin
      end
      CMD_TRIGGER: begin
        play_position_next = trig_pos;
        play_backward_next = reverse_on;
        voice_on_next      = 1'b1;
      end
      CMD_STOP: begin
        voice_on_next = 1'b0;
      end
      CMD_TICK: begin
        if (voice_on) begin
          play_position_next = tick_pos;
          play_backward_next = (at_edge && loop_on && pingpong_on) ? !pb : pb;
          voice_on_next      = !rel;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_position <= '0;
      play_backward <= 1'b0;
      voice_on      <= 1'b0;
    end else if (accept) begin
      play_position <= play_position_next;
      play_backward <= play_backward_next;
      voice_on      <= voice_on_next;
    end
  end

  // read addresses and frame range checks against the used count
  assign cnt      = (IW'(sample_count) < IW'(SAMPLE_DEPTH)) ? IW'(sample_count)
                                                          : IW'(SAMPLE_DEPTH);
  assign idx      = IW'(play_position[PW-1:FRAC_BITS]);
  assign idx1     = idx + IW'(1);
  assign addr_ext = IW'(addr);
  assign word_ext = MW'(sample_word);

  always_comb begin
    item.wr           = (cmd == CMD_WRITE) && (addr_ext < IW'(SAMPLE_DEPTH));
    item.rd           = tick_on && (idx < cnt);
    item.single       = idx1 >= cnt;
    item.voice_active = voice_on_next;
    item.released     = tick_on && rel;
    item.playhead     = play_position_next[PW-1:FRAC_BITS];
  end

  spv_sample_path #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_path (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (path_ready),
    .item      (item),
    .waddr     (addr_ext[AW-1:0]),
    .wdata     (word_ext[SAMPLE_BITS-1:0]),
    .rd_addr_a (idx[AW-1:0]),
    .rd_addr_b (idx1[AW-1:0]),
    .frac      (play_position[FRAC_BITS-1:0]),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // a tick keeps the playhead inside the range it saw
  a_tick_in_range: assert property (@(posedge clk) disable iff (rst)
    accept && tick_on |=> (play_position >= $past(s_pos)) && (play_position <= $past(e_pos)))
    else $error("playhead left the range after a tick");

  // a one-shot stop leaves the voice idle
  a_release_idle: assert property (@(posedge clk) disable iff (rst)
    accept && tick_on && rel |=> !voice_on)
    else $error("voice still on after a one-shot stop");

  // release only without looping and never on an active voice
  a_release_flags: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && item.released |-> !loop_on && !item.voice_active)
    else $error("release flagged with looping or an active voice");

endmodule

// File: tb/sv/spv_voice_checker.sv
`timescale 1ns / 100ps
// checker for the sampler voice: tracks requests, predicts each result and compares
module spv_voice_checker
  import spv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [CMD_W-1:0]      s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output int                    fail_count,
  output int                    pending,
  output int                    checked,
  output int                    release_count
);

  localparam int     FRAC  = FRAC_BITS_DEF;
  localparam longint DEPTH = SAMPLE_DEPTH_DEF;

  // one result as it leaves the block
  typedef struct packed {
    logic [OUT_W-1:0]   sample;
    logic               active;
    logic               rel;
    logic [FRAME_W-1:0] frame;
  } voice_out_t;

  // predicted voice state and register copy
  logic signed [WORD_W-1:0] wave_mem [SAMPLE_DEPTH_DEF];
  longint                   playhead_pos;
  logic                     backward;
  logic                     playing;
  logic [START_W-1:0]       cfg_start;
  logic [FRAME_W-1:0]       cfg_end;
  logic [STEP_W-1:0]        cfg_step;
  logic [FRAME_W-1:0]       cfg_count;
  logic                     cfg_rev, cfg_neg, cfg_loop, cfg_pp;

  voice_out_t voice_out_q[$];
  int errors   = 0;
  int compared = 0;
  int releases = 0;

  function automatic void voice_reset();
    playhead_pos = 0;
    backward     = 1'b0;
    playing      = 1'b0;
    cfg_start    = '0;
    cfg_end      = 17'd65536;
    cfg_step     = 20'd65536;
    cfg_count    = 17'd65536;
    cfg_rev      = 1'b0;
    cfg_neg      = 1'b0;
    cfg_loop     = 1'b0;
    cfg_pp       = 1'b0;
    voice_out_q.delete();
  endfunction

  function automatic void write_setting(logic [2:0] idx, logic [PDATA_W-1:0] v);
    case (reg_idx_t'(idx))
      REG_RANGE_START:  cfg_start = v[START_W-1:0];
      REG_RANGE_END:    cfg_end   = v[FRAME_W-1:0];
      REG_STEP_RATE:    cfg_step  = v[STEP_W-1:0];
      REG_SAMPLE_COUNT: cfg_count = v[FRAME_W-1:0];
      REG_REVERSE_ON:   cfg_rev   = v[0];
      REG_SPEED_NEG:    cfg_neg   = v[0];
      REG_LOOP_ON:      cfg_loop  = v[0];
      REG_PINGPONG_ON:  cfg_pp    = v[0];
      default: ;
    endcase
  endfunction

  function automatic longint lo_bound();
    return longint'(cfg_start) << FRAC;
  endfunction

  // end of range never falls below start plus one frame
  function automatic longint hi_bound();
    longint e;
    e = longint'(cfg_end);
    if (e < longint'(cfg_start) + 1) e = longint'(cfg_start) + 1;
    return e << FRAC;
  endfunction

  // linear interpolation between frame i and i+1, zero past the valid frames
  function automatic logic [OUT_W-1:0] interp_at(longint pos);
    longint cnt, idx, frac, a, b, d;
    cnt = longint'(cfg_count);
    if (cnt > DEPTH) cnt = DEPTH;
    idx  = pos >>> FRAC;
    frac = pos & ((longint'(1) << FRAC) - 1);
    if (idx + 1 >= cnt) begin
      if (idx < cnt) return wave_mem[16'(idx)];
      return '0;
    end
    a = wave_mem[16'(idx)];
    b = wave_mem[16'(idx + 1)];
    d = (b - a) * frac + (longint'(1) << (FRAC - 1));
    return 16'(a + (d >>> FRAC));
  endfunction

  // step the playhead, handle the range edges; true when a one-shot ends play
  function automatic logic move_playhead();
    longint lo, hi, p;
    logic   at_end, at_start, stopped;
    lo       = lo_bound();
    hi       = hi_bound();
    p        = playhead_pos;
    at_end   = 1'b0;
    at_start = 1'b0;
    stopped  = 1'b0;
    if (backward ^ cfg_neg) begin
      p        = p - longint'(cfg_step);
      at_start = (p <= lo);
    end else begin
      p      = p + longint'(cfg_step);
      at_end = (p >= hi);
    end
    if (at_end || at_start) begin
      if (cfg_loop && cfg_pp) begin
        backward = !backward;
        p = at_end ? hi : lo;
      end else if (cfg_loop) begin
        p = at_end ? lo : hi;
      end else begin
        stopped = 1'b1;
      end
    end
    if (p < lo) p = lo;
    if (p > hi) p = hi;
    playhead_pos = p;
    return stopped;
  endfunction

  // apply one request to the predicted voice and work out its result
  function automatic voice_out_t play_request(cmd_t kind, logic [IN_DATA_W-1:0] req);
    voice_out_t r;
    longint     lo, hi, p;
    r = '0;
    case (kind)
      CMD_WRITE: wave_mem[req[15:0]] = req[31:16];
      CMD_TRIGGER: begin
        lo = lo_bound();
        hi = hi_bound();
        p  = longint'(req[48:32]) << FRAC;
        if (p < lo) p = lo;
        if (p > hi) p = hi;
        backward = cfg_rev;
        // a backward start at the range start jumps to the end, unless the given position is asked for
        if (!req[49] && (cfg_rev != cfg_neg) && p <= lo) p = hi;
        playhead_pos = p;
        playing      = 1'b1;
      end
      CMD_STOP: playing = 1'b0;
      default: begin
        if (playing) begin
          if (!cfg_pp) backward = cfg_rev;
          r.sample = interp_at(playhead_pos);
          if (move_playhead()) begin
            r.rel   = 1'b1;
            playing = 1'b0;
            releases++;
          end
        end
      end
    endcase
    r.active = playing;
    r.frame  = FRAME_W'(playhead_pos >>> FRAC);
    return r;
  endfunction

  function automatic void compare_result(logic [OUT_DATA_W-1:0] data);
    voice_out_t got, want;
    got.sample = data[15:0];
    got.active = data[16];
    got.rel    = data[17];
    got.frame  = data[34:18];
    if (voice_out_q.size() == 0) begin
      if (errors < 10)
        $display("%0t: result with nothing outstanding: sample %0d frame %0d",
                 $time, $signed(got.sample), got.frame);
      errors++;
      return;
    end
    want = voice_out_q.pop_front();
    compared++;
    if (got.sample !== want.sample || got.active !== want.active ||
        got.rel !== want.rel || got.frame !== want.frame) begin
      if (errors < 10) begin
        $display("%0t: result %0d differs", $time, compared);
        $display("  want sample %0d active %0b released %0b frame %0d",
                 $signed(want.sample), want.active, want.rel, want.frame);
        $display("  got  sample %0d active %0b released %0b frame %0d",
                 $signed(got.sample), got.active, got.rel, got.frame);
      end
      errors++;
    end
  endfunction

  // results leave before new requests are booked within one edge
  always @(posedge clk) begin
    if (rst) begin
      voice_reset();
    end else begin
      if (m_tvalid && m_tready) compare_result(m_tdata);
      if (psel && penable && pwrite && pready) write_setting(paddr[4:2], pwdata);
      if (s_tvalid && s_tready) voice_out_q.push_back(play_request(cmd_t'(s_tuser), s_tdata));
    end
    fail_count    <= errors;
    pending       <= voice_out_q.size();
    checked       <= compared;
    release_count <= releases;
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// testbench top for the sampler voice: clock, reset, requests, settings and verdict
module tb_top;
  import spv_pkg::*;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // addr[15:0], sample_word[31:16], start_frame[48:32], use_given_pos[49]
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  // cmd[1:0]
  logic [CMD_W-1:0]      s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // sample_out[15:0], voice_active[16], released[17], playhead_frame[34:18]
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [PADDR_W-1:0]    paddr    = '0;
  logic [PDATA_W-1:0]    pwdata   = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  int fail_count, pending, checked, release_count;

  // current setting and the stretch of sample memory that ticks may read
  logic [START_W-1:0] set_start;
  logic [FRAME_W-1:0] set_end;
  logic [STEP_W-1:0]  set_step;
  logic [FRAME_W-1:0] set_count;
  logic               set_rev, set_neg, set_loop, set_pp;
  int                 end_eff, read_lo, read_hi;
  bit                 filled [SAMPLE_DEPTH_DEF];

  int burst_left    = 0;
  int items_sent    = 0;
  int settings_used = 0;
  int stall_left    = 0;
  int stall_mode    = 0;
  logic [3:0] stall_phase = '0;

  sample_playback_voice u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  spv_voice_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending), .checked(checked),
    .release_count(release_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver back-pressure: modes of random length, from never stalling to mostly stalling
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 4) == 0);
      default: m_tready <= (stall_phase[2:0] != 3'd3) && (stall_phase[3:1] != 3'd6);
    endcase
  end

  // one request, sent in bursts with random gaps between them
  task automatic push_request(cmd_t kind, logic [IN_DATA_W-1:0] payload);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= payload;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // ignored fields carry random bits so bits 49:0 of the bus toggle
  function automatic logic [IN_DATA_W-1:0] noise_payload();
    return {6'b0, 18'($urandom_range(0, 262143)), 32'($urandom)};
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_write(logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] word);
    logic [IN_DATA_W-1:0] p;
    p = noise_payload();
    p[15:0]  = addr;
    p[31:16] = word;
    push_request(CMD_WRITE, p);
    filled[addr] = 1'b1;
  endtask

  task automatic send_trigger(logic [FRAME_W-1:0] from, logic given);
    logic [IN_DATA_W-1:0] p;
    p = noise_payload();
    p[48:32] = from;
    p[49]    = given;
    push_request(CMD_TRIGGER, p);
  endtask

  task automatic send_plain(cmd_t kind);
    push_request(kind, noise_payload());
  endtask

  // setup and access phase, write lands when psel, penable and pready are high
  task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending, wait for every result, then let the pipeline go quiet
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // frames a tick may read: start up to one past the end, below the valid count
  function automatic void find_read_span();
    int c_eff;
    end_eff = (int'(set_end) < int'(set_start) + 1) ? int'(set_start) + 1 : int'(set_end);
    c_eff   = (int'(set_count) > SAMPLE_DEPTH_DEF) ? SAMPLE_DEPTH_DEF : int'(set_count);
    read_lo = int'(set_start);
    read_hi = (end_eff + 1 < c_eff - 1) ? end_eff + 1 : c_eff - 1;
  endfunction

  function automatic void load_setting(logic [START_W-1:0] st, logic [FRAME_W-1:0] en,
                                       logic [STEP_W-1:0] sp, logic [FRAME_W-1:0] cn,
                                       logic rv, logic ng, logic lp, logic pp);
    set_start = st;
    set_end   = en;
    set_step  = sp;
    set_count = cn;
    set_rev   = rv;
    set_neg   = ng;
    set_loop  = lp;
    set_pp    = pp;
    find_read_span();
  endfunction

  // random setting, kept to a short stretch of memory that can be filled cheaply
  function automatic void random_setting();
    case ($urandom_range(0, 5))
      0: set_start = '0;
      1: set_start = 16'hFFFF;
      default: set_start = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: set_end = '0;
      1: set_end = 17'(set_start + $urandom_range(1, 8));
      2: set_end = 17'(set_start + $urandom_range(1, 64));
      3: set_end = 17'($urandom_range(0, 131071));
      default: set_end = 17'd65536;
    endcase
    case ($urandom_range(0, 5))
      0: set_step = '0;
      1: set_step = 20'hFFFFF;
      2: set_step = 20'($urandom_range(1, 65536));
      3: set_step = 20'($urandom_range(0, 1048575));
      default: set_step = 20'($urandom_range(16'h4000, 20'h30000));
    endcase
    case ($urandom_range(0, 6))
      0: set_count = '0;
      1: set_count = 17'd1;
      2: set_count = 17'd65536;
      3: set_count = 17'h1FFFF;
      4: set_count = 17'($urandom_range(0, 131071));
      default: set_count = 17'(set_start + $urandom_range(0, 80));
    endcase
    set_rev  = 1'($urandom_range(0, 1));
    set_neg  = 1'($urandom_range(0, 1));
    set_loop = 1'($urandom_range(0, 1));
    set_pp   = 1'($urandom_range(0, 1));
    find_read_span();
    if (read_hi - read_lo > 96) begin
      if ($urandom_range(0, 1)) set_end = 17'(set_start + $urandom_range(1, 64));
      else set_count = 17'(set_start + $urandom_range(0, 64));
      find_read_span();
    end
  endfunction

  task automatic program_setting();
    write_reg(REG_RANGE_START, PDATA_W'(set_start));
    write_reg(REG_RANGE_END, PDATA_W'(set_end));
    write_reg(REG_STEP_RATE, PDATA_W'(set_step));
    write_reg(REG_SAMPLE_COUNT, PDATA_W'(set_count));
    write_reg(REG_REVERSE_ON, PDATA_W'(set_rev));
    write_reg(REG_SPEED_NEG, PDATA_W'(set_neg));
    write_reg(REG_LOOP_ON, PDATA_W'(set_loop));
    write_reg(REG_PINGPONG_ON, PDATA_W'(set_pp));
    settings_used++;
  endtask

  // every frame a tick could read holds a written word before the first trigger
  task automatic fill_reads();
    for (int a = read_lo; a <= read_hi; a++)
      if (!filled[a]) send_write(16'(a), random_word());
  endtask

  // mostly trigger and tick traffic, with stops and memory writes mixed in
  task automatic random_request();
    int               roll;
    logic [FRAME_W-1:0] from;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      send_plain(CMD_TICK);
    end else if (roll < 68) begin
      case ($urandom_range(0, 5))
        0: from = '0;
        1: from = 17'h1FFFF;
        2: from = 17'(set_start);
        3: from = 17'(end_eff);
        4: from = 17'(set_start + $urandom_range(0, end_eff - int'(set_start)));
        default: from = 17'($urandom_range(0, 131071));
      endcase
      send_trigger(from, 1'($urandom_range(0, 1)));
    end else if (roll < 73) begin
      send_plain(CMD_STOP);
    end else if (roll < 88 && read_hi >= read_lo) begin
      send_write(16'($urandom_range(read_lo, read_hi)), random_word());
    end else begin
      send_write(16'($urandom), random_word());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // opening: small one-shot range, extreme words, idle requests, clamped triggers
    load_setting(16'd0, 17'd8, 20'h08000, 17'd8, 1'b0, 1'b0, 1'b0, 1'b0);
    program_setting();
    send_write(16'd0, 16'h7FFF);
    send_write(16'd1, 16'h8000);
    send_write(16'd2, 16'h7FFF);
    send_write(16'd3, 16'h0000);
    fill_reads();
    send_write(16'hFFFF, 16'hFFFF);
    send_plain(CMD_TICK);
    send_plain(CMD_STOP);
    send_trigger(17'h1FFFF, 1'b1);
    send_plain(CMD_TICK);
    send_trigger(17'd0, 1'b0);
    repeat (4) send_plain(CMD_TICK);
    send_plain(CMD_STOP);
    send_plain(CMD_TICK);
    send_trigger(17'd7, 1'b1);
    repeat (3) send_plain(CMD_TICK);
    send_plain(CMD_STOP);
    wait_drained();

    // register extremes first, then random settings
    for (int k = 1; items_sent < 1650; k++) begin
      case (k)
        1: load_setting(16'hFFFF, 17'h1FFFF, 20'hFFFFF, 17'h1FFFF, 1'b1, 1'b0, 1'b1, 1'b1);
        2: load_setting(16'd0, 17'd0, 20'd0, 17'd0, 1'b0, 1'b1, 1'b1, 1'b0);
        3: load_setting(16'd65472, 17'd65536, 20'h18000, 17'd65536, 1'b1, 1'b1, 1'b0, 1'b0);
        4: load_setting(16'd100, 17'd140, 20'h02800, 17'd130, 1'b0, 1'b1, 1'b1, 1'b1);
        default: random_setting();
      endcase
      program_setting();
      fill_reads();
      repeat ($urandom_range(60, 130)) random_request();
      send_plain(CMD_STOP);
      wait_drained();
    end

    $display("covered %0d requests under %0d register settings", items_sent, settings_used);
    $display("%0d results compared, %0d one-shot releases", checked, release_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
